[design/traffic_light_priority_sequencer_core_defines.svh]
// Assertion macros shared by the traffic light sequencer RTL.
`ifndef TRAFFIC_LIGHT_PRIORITY_SEQUENCER_CORE_DEFINES_SVH
`define TRAFFIC_LIGHT_PRIORITY_SEQUENCER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define TLPS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Check that the antecedent implies the consequent in the same cycle.
`define TLPS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the antecedent implies the consequent in the next cycle.
`define TLPS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define TLPS_ASSERT(lbl, clk, rst, prop, msg)
`define TLPS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define TLPS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[design/tlps_pkg.sv]
// Types, constants and register map of the traffic light sequencer.
`default_nettype none

package tlps_pkg;

   localparam int NUM_APPROACHES_DEF = 4;
   localparam int SHOWN_W            = 4;   // approaches with lamps and counts
   localparam int COUNT_W            = 8;
   localparam int REG_W              = 16;
   localparam int TIMER_W            = 24;
   localparam int SERVE_W            = 2;
   localparam int CSR_ADDR_W         = 4;
   localparam int CSR_DATA_W         = 32;
   localparam int REQ_DATA_W         = 2 * SHOWN_W * COUNT_W;
   localparam int RSP_DATA_W         = 16;

   localparam logic [REG_W-1:0]   BLINK_ON_RESET    = REG_W'(300);
   localparam logic [REG_W-1:0]   BLINK_OFF_RESET   = REG_W'(200);
   localparam logic [REG_W-1:0]   TICKS_CAR_RESET   = REG_W'(2000);
   localparam logic [REG_W-1:0]   EMPTY_GREEN_RESET = REG_W'(500);
   localparam logic [COUNT_W-1:0] CARS_RESET        = COUNT_W'(5);

   typedef enum logic [1:0] {
      PH_ENTERING  = 2'd0,
      PH_BLINK_ON  = 2'd1,
      PH_BLINK_OFF = 2'd2,
      PH_STEADY    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      REG_BLINK_ON     = 2'd0,
      REG_BLINK_OFF    = 2'd1,
      REG_TICKS_CAR    = 2'd2,
      REG_EMPTY_GREEN  = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic [REG_W-1:0] blink_on_ticks;
      logic [REG_W-1:0] blink_off_ticks;
      logic [REG_W-1:0] ticks_per_car;
      logic [REG_W-1:0] empty_green_ticks;
   } cfg_type;

   // Counts of one update, approach 0 in the lowest byte of each group.
   typedef struct packed {
      logic [SHOWN_W-1:0][COUNT_W-1:0] ambulances;
      logic [SHOWN_W-1:0][COUNT_W-1:0] cars;
   } req_type;

   typedef struct packed {
      logic               update_ack;
      logic               priority_active;
      logic [SERVE_W-1:0] serving_approach;
      logic [SHOWN_W-1:0] red_lamps;
      logic [SHOWN_W-1:0] green_lamps;
   } rsp_type;

endpackage

`default_nettype wire

[design/tlps_csr.sv]
// Configuration register file behind the APB-style port.
`default_nettype none

module tlps_csr
   import tlps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_reg_type reg_sel;
   logic        wr_en;
   logic [REG_W-1:0] rd_val;

   assign reg_sel    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_BLINK_ON:    cfg_in.blink_on_ticks    = csr_pwdata[REG_W-1:0];
            REG_BLINK_OFF:   cfg_in.blink_off_ticks   = csr_pwdata[REG_W-1:0];
            REG_TICKS_CAR:   cfg_in.ticks_per_car     = csr_pwdata[REG_W-1:0];
            REG_EMPTY_GREEN: cfg_in.empty_green_ticks = csr_pwdata[REG_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_BLINK_ON:    rd_val = cfg_ff.blink_on_ticks;
         REG_BLINK_OFF:   rd_val = cfg_ff.blink_off_ticks;
         REG_TICKS_CAR:   rd_val = cfg_ff.ticks_per_car;
         REG_EMPTY_GREEN: rd_val = cfg_ff.empty_green_ticks;
      endcase
   end

   assign csr_prdata = {{(CSR_DATA_W-REG_W){1'b0}}, rd_val};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blink_on_ticks    <= BLINK_ON_RESET;
         cfg_ff.blink_off_ticks   <= BLINK_OFF_RESET;
         cfg_ff.ticks_per_car     <= TICKS_CAR_RESET;
         cfg_ff.empty_green_ticks <= EMPTY_GREEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[design/tlps_seq.sv]
// Sequencer state, count stores and the single-pass next-state logic.
`default_nettype none
`include "traffic_light_priority_sequencer_core_defines.svh"

module tlps_seq
   import tlps_pkg::*;
#(
   parameter int NUM_APPROACHES = NUM_APPROACHES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic acc,
   input  wire logic action,
   input  req_type   req,
   input  cfg_type   cfg,
   output rsp_type   rsp_next
);

   localparam int IDX_W = $clog2(NUM_APPROACHES);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_APPROACHES - 1);
   localparam logic [SHOWN_W-1:0] SHOWN_MASK = (NUM_APPROACHES >= SHOWN_W) ?
      {SHOWN_W{1'b1}} : SHOWN_W'((1 << NUM_APPROACHES) - 1);

   phase_type          phase_ff, phase_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [COUNT_W-1:0] cars_ff [NUM_APPROACHES];
   logic [COUNT_W-1:0] amb_ff  [NUM_APPROACHES];
   logic [COUNT_W-1:0] cars_eff [NUM_APPROACHES];
   logic [COUNT_W-1:0] amb_eff  [NUM_APPROACHES];

   logic               tick, entering, first_amb, sa_short, advance;
   phase_type          sa_phase, entry_phase;
   logic [IDX_W-1:0]   idx_inc, rd_idx;
   logic [COUNT_W-1:0] first_cars, rd_cars, rd_amb;
   logic [TIMER_W-1:0] prod, entry_timer, base_timer;
   logic [IDX_W+1:0]   idx_wide;
   logic [SHOWN_W-1:0] lamp_bit;

   // Counts as seen by this item: an update is stored before anything else.
   always_comb begin
      for (int i = 0; i < NUM_APPROACHES; i++) begin
         if (action && (i < SHOWN_W)) begin
            cars_eff[i] = req.cars[2'(i)];
            amb_eff[i]  = req.ambulances[2'(i)];
         end else begin
            cars_eff[i] = cars_ff[i];
            amb_eff[i]  = amb_ff[i];
         end
      end
   end

   assign tick       = ~action;
   assign entering   = (phase_ff == PH_ENTERING);
   assign first_amb  = (amb_eff[0] != '0);
   assign first_cars = cars_eff[0];
   assign idx_inc    = (idx_ff == IDX_LAST) ? '0 : idx_ff + IDX_W'(1);

   // Phase and timer shortness after the entry that resolves the reset phase.
   // Entering only happens at approach 0, so its counts come from entry 0.
   always_comb begin
      if (entering) begin
         sa_phase = first_amb ? PH_BLINK_ON : PH_STEADY;
         if (first_amb) begin
            sa_short = (cfg.blink_on_ticks <= REG_W'(1));
         end else if (first_cars != '0) begin
            sa_short = (cfg.ticks_per_car == '0) ||
                       ((first_cars == COUNT_W'(1)) && (cfg.ticks_per_car == REG_W'(1)));
         end else begin
            sa_short = (cfg.empty_green_ticks <= REG_W'(1));
         end
      end else begin
         sa_phase = phase_ff;
         sa_short = (timer_ff <= TIMER_W'(1));
      end
   end

   assign advance = tick && sa_short && (sa_phase == PH_STEADY);
   assign rd_idx  = advance ? idx_inc : idx_ff;
   assign rd_cars = cars_eff[rd_idx];
   assign rd_amb  = amb_eff[rd_idx];
   assign prod    = TIMER_W'(rd_cars) * TIMER_W'(cfg.ticks_per_car);

   // Entry of the approach at the read index.
   always_comb begin
      if (rd_amb != '0) begin
         entry_phase = PH_BLINK_ON;
         entry_timer = TIMER_W'(cfg.blink_on_ticks);
      end else begin
         entry_phase = PH_STEADY;
         entry_timer = (rd_cars != '0) ? prod : TIMER_W'(cfg.empty_green_ticks);
      end
   end

   assign base_timer = entering ? entry_timer : timer_ff;

   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      idx_in   = idx_ff;
      if (tick) begin
         if (!sa_short) begin
            phase_in = sa_phase;
            timer_in = base_timer - TIMER_W'(1);
         end else begin
            unique case (sa_phase)
               PH_BLINK_ON: begin
                  phase_in = PH_BLINK_OFF;
                  timer_in = TIMER_W'(cfg.blink_off_ticks);
               end
               PH_BLINK_OFF: begin
                  phase_in = entry_phase;
                  timer_in = entry_timer;
               end
               PH_STEADY: begin
                  idx_in   = idx_inc;
                  phase_in = entry_phase;
                  timer_in = entry_timer;
               end
               PH_ENTERING: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end else if (entering) begin
         phase_in = entry_phase;
         timer_in = entry_timer;
      end
   end

   // Lamps follow from the state after the item; approaches above 3 are dark.
   assign idx_wide = {2'b00, idx_in};
   assign lamp_bit = (idx_wide < (IDX_W+2)'(SHOWN_W)) ?
                     (SHOWN_W'(1) << idx_wide[1:0]) : '0;

   always_comb begin
      rsp_next.update_ack       = action;
      rsp_next.priority_active  = (phase_in == PH_BLINK_ON) || (phase_in == PH_BLINK_OFF);
      rsp_next.serving_approach = idx_wide[SERVE_W-1:0];
      rsp_next.green_lamps      = ((phase_in == PH_BLINK_ON) || (phase_in == PH_STEADY)) ?
                                  lamp_bit : '0;
      rsp_next.red_lamps        = (phase_in == PH_ENTERING) ? '0 : (SHOWN_MASK & ~lamp_bit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ENTERING;
         timer_ff <= '0;
         idx_ff   <= '0;
      end else if (acc) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_APPROACHES; i++) begin
            cars_ff[i] <= CARS_RESET;
            amb_ff[i]  <= '0;
         end
      end else if (acc) begin
         for (int i = 0; i < NUM_APPROACHES; i++) begin
            cars_ff[i] <= cars_eff[i];
            amb_ff[i]  <= amb_eff[i];
         end
      end
   end

   `TLPS_ASSERT(a_green_onehot, clock, reset, $onehot0(rsp_next.green_lamps), "two greens lit")
   `TLPS_ASSERT(a_red_green_excl, clock, reset,
      (rsp_next.green_lamps & rsp_next.red_lamps) == '0, "red and green lit together")
   `TLPS_ASSERT_NXT(a_enter_once, clock, reset, phase_ff != PH_ENTERING,
      phase_ff != PH_ENTERING, "returned to entering phase")
   `TLPS_ASSERT_NXT(a_idx_hold, clock, reset, !acc, $stable(idx_ff), "index moved without transfer")

endmodule

`default_nettype wire

[design/tlps_out.sv]
// Result register with a skid stage toward the result channel.
`default_nettype none
`include "traffic_light_priority_sequencer_core_defines.svh"

module tlps_out
   import tlps_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  rsp_type   push_data,
   output logic      can_push,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   output rsp_type   rsp_data
);

   logic    main_valid_ff, skid_valid_ff;
   rsp_type main_ff, skid_ff;
   logic    pop;

   assign pop        = main_valid_ff & rsp_tready;
   assign can_push   = ~skid_valid_ff;
   assign rsp_tvalid = main_valid_ff;
   assign rsp_data   = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_ff <= push_data;
         end else begin
            main_ff <= push_data;
         end
      end
   end

   `TLPS_ASSERT_IMP(a_skid_needs_main, clock, reset, skid_valid_ff, main_valid_ff,
      "skid holds data while result register is empty")
   `TLPS_ASSERT_NXT(a_skid_hold, clock, reset, skid_valid_ff && !rsp_tready,
      skid_valid_ff && $stable(skid_ff), "skid entry lost while stalled")

endmodule

`default_nettype wire

[design/traffic_light_priority_sequencer_core.sv]
// Top level of the traffic light sequencer with emergency priority.
//
// Usage: every transfer on the req_ channel is one item. req_tuser = 0 is a
// one-millisecond tick, req_tuser = 1 replaces all car and ambulance counts
// (approach 0 in the lowest byte of each group in req_tdata). Each item gives
// exactly one transfer on the rsp_ channel with the lamps, the served approach,
// the blink flag and the update acknowledge as they stand after the item.
// Throughput: one item per cycle while req_tready is high; the next-state logic
// (one 8x16 multiply for the steady green time, then a 24-bit decrement and
// selection) completes in a single pass from the accepted request into the
// state and result registers. Stall: a result register plus a skid stage hold
// up to two results, so one more item is taken while a result waits;
// req_tready drops only when both are full and rises again in the cycle after
// rsp_tready drains one. Reset: synchronous, active high. All approaches hold
// five cars and no ambulances, approach 0 is pending entry, and timing
// registers return to 300/200/2000/500 ms. Write csr_ registers only while no
// item is in flight.
`default_nettype none

module traffic_light_priority_sequencer_core
   import tlps_pkg::*;
#(
   parameter int NUM_APPROACHES = NUM_APPROACHES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // cars_north, cars_east, cars_south, cars_west, ambulances_north,
   // ambulances_east, ambulances_south, ambulances_west (8 bits each)
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // action
   input  wire logic                  req_tuser,
   // Result channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // green_lamps[3:0], red_lamps[7:4], serving_approach[9:8],
   // priority_active[10], update_ack[11], zero fill[15:12]
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   // Configuration port.
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type cfg;
   req_type req;
   rsp_type rsp_next, rsp_data;
   logic    acc;
   logic    can_push;

   assign req        = req_type'(req_tdata);
   assign req_tready = can_push;
   assign acc        = req_tvalid & can_push;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(rsp_type)){1'b0}}, rsp_data};

   // Timing registers.
   tlps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Advance the round-robin sequencer once per accepted transfer.
   tlps_seq #(
      .NUM_APPROACHES (NUM_APPROACHES)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .acc      (acc),
      .action   (req_tuser),
      .req      (req),
      .cfg      (cfg),
      .rsp_next (rsp_next)
   );

   // Hold results until the receiver takes them.
   tlps_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (acc),
      .push_data  (rsp_next),
      .can_push   (can_push),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

[tb/tb_traffic_light_priority_sequencer_core.sv]
// Self-checking testbench for the traffic light priority sequencer core.
module tb_traffic_light_priority_sequencer_core;
   import tlps_pkg::*;

   localparam int CYCLE_LIMIT  = 100000;  // generous bound on the run length
   localparam int HOLD_CYCLES  = 64;      // long result-side hold-off
   localparam int SETTLE_CYCLES = 4;      // settling margin after the final drain
   localparam bit ACT_TICK     = 1'b0;
   localparam bit ACT_UPDATE   = 1'b1;

   // Lamp state predictor and the queue of lamp states still owed by the block.
   class lamp_scoreboard;
      logic [REG_W-1:0]     blink_on, blink_off, per_car, empty_green;
      logic [SERVE_W-1:0]   serving;
      phase_type            phase;
      logic [TIMER_W-1:0]   timer;
      logic [COUNT_W-1:0]   cars [SHOWN_W];
      logic [COUNT_W-1:0]   ambulances [SHOWN_W];
      logic [2*SHOWN_W-1:0] lamps;   // green in the low nibble, red in the high nibble
      rsp_type              lamps_due [$];
      int                   errors, results_seen, blink_results, updates_seen, entries_seen;

      function new();
         blink_on    = BLINK_ON_RESET;
         blink_off   = BLINK_OFF_RESET;
         per_car     = TICKS_CAR_RESET;
         empty_green = EMPTY_GREEN_RESET;
         serving     = '0;
         phase       = PH_ENTERING;
         timer       = '0;
         lamps       = '0;
         foreach (cars[i]) begin
            cars[i]       = CARS_RESET;
            ambulances[i] = '0;
         end
         errors        = 0;
         results_seen  = 0;
         blink_results = 0;
         updates_seen  = 0;
         entries_seen  = 0;
      endfunction

      function void write_reg(csr_reg_type index, logic [REG_W-1:0] value);
         case (index)
            REG_BLINK_ON:    blink_on    = value;
            REG_BLINK_OFF:   blink_off   = value;
            REG_TICKS_CAR:   per_car     = value;
            REG_EMPTY_GREEN: empty_green = value;
         endcase
      endfunction

      function logic [REG_W-1:0] reg_value(csr_reg_type index);
         case (index)
            REG_BLINK_ON:    return blink_on;
            REG_BLINK_OFF:   return blink_off;
            REG_TICKS_CAR:   return per_car;
            default:         return empty_green;
         endcase
      endfunction

      function void set_green(bit lit);
         lamps[serving] = lit;
      endfunction

      function void start_steady();
         if (cars[serving] != '0)
            timer = TIMER_W'(cars[serving]) * TIMER_W'(per_car);
         else
            timer = TIMER_W'(empty_green);
         phase = PH_STEADY;
         set_green(1'b1);
      endfunction

      function void start_blink();
         timer = TIMER_W'(blink_on);
         phase = PH_BLINK_ON;
         set_green(1'b1);
      endfunction

      function void enter_approach();
         logic [SHOWN_W-1:0] onehot;
         onehot = SHOWN_W'(1) << serving;
         lamps = {~onehot, lamps[SHOWN_W-1:0] & onehot};
         entries_seen++;
         if (ambulances[serving] != '0)
            start_blink();
         else
            start_steady();
      endfunction

      // Advance the light state by one accepted item and queue the lamp state it yields.
      function void predict_lamps(bit update, req_type counts);
         rsp_type due;
         if (update) begin
            for (int i = 0; i < SHOWN_W; i++) begin
               cars[i]       = counts.cars[i];
               ambulances[i] = counts.ambulances[i];
            end
            updates_seen++;
         end
         if (phase == PH_ENTERING)
            enter_approach();
         if (!update) begin
            if (timer > 1) begin
               timer = timer - 1'b1;
            end else if (phase == PH_BLINK_ON) begin
               timer = TIMER_W'(blink_off);
               phase = PH_BLINK_OFF;
               set_green(1'b0);
            end else if (phase == PH_BLINK_OFF) begin
               if (ambulances[serving] != '0)
                  start_blink();
               else
                  start_steady();
            end else begin
               serving = SERVE_W'((serving + 1) % NUM_APPROACHES_DEF);
               enter_approach();
            end
         end
         due.green_lamps      = lamps[SHOWN_W-1:0];
         due.red_lamps        = lamps[2*SHOWN_W-1:SHOWN_W];
         due.serving_approach = serving;
         due.priority_active  = (phase == PH_BLINK_ON) || (phase == PH_BLINK_OFF);
         due.update_ack       = update;
         lamps_due.push_back(due);
      endfunction

      function void compare(string field, int unsigned due, int unsigned got);
         if (due != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, due, got);
         end
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data);
         rsp_type got, due;
         got = data[$bits(rsp_type)-1:0];
         if (lamps_due.size() == 0) begin
            errors++;
            $display("%0t: result %h arrived with nothing outstanding", $time, data);
            return;
         end
         due = lamps_due.pop_front();
         results_seen++;
         if (got.priority_active)
            blink_results++;
         compare("green_lamps", due.green_lamps, got.green_lamps);
         compare("red_lamps", due.red_lamps, got.red_lamps);
         compare("serving_approach", due.serving_approach, got.serving_approach);
         compare("priority_active", due.priority_active, got.priority_active);
         compare("update_ack", due.update_ack, got.update_ack);
         compare("zero fill", 0, data[RSP_DATA_W-1:$bits(rsp_type)]);
      endfunction

      function int pending();
         return lamps_due.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   lamp_scoreboard board;
   int             cycle_count = 0;
   int             items_sent = 0;
   bit             quiet_run = 1'b0;     // suppress idling on both sides
   bit             rsp_hold_req = 1'b0;  // ask the receiver for one long hold-off

   traffic_light_priority_sequencer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Watch both channels at every edge: predict on each input transfer, check on each
   // result transfer. The prediction for an item is queued before its result arrives.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.predict_lamps(req_tuser, req_type'(req_tdata));
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tdata);
      end
   end

   // Bound the run; a hung handshake lands here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run stalled with %0d lamp states outstanding", $time, board.pending());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Result side: stall at random about 10% of the time, never while the run is quiet,
   // and once hold off for a long stretch so the block fills and drops req_tready.
   initial begin
      rsp_tready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (quiet_run) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 10);
         end
      end
   end

   function automatic req_type make_counts(input logic [SHOWN_W*COUNT_W-1:0] car_bytes,
                                           input logic [SHOWN_W*COUNT_W-1:0] ambulance_bytes);
      req_type counts;
      counts.cars       = car_bytes;
      counts.ambulances = ambulance_bytes;
      return counts;
   endfunction

   // Ticks ignore the data bus; fill it with junk so those bits toggle too.
   function automatic req_type noise_counts();
      return req_type'({$urandom(), $urandom()});
   endfunction

   // Mostly short queues so the approaches rotate; now and then a heavy lane or a burst of
   // ambulances. Zero ambulances often enough that blinking ends.
   function automatic req_type random_counts();
      req_type counts;
      int      pick;
      for (int i = 0; i < SHOWN_W; i++) begin
         counts.cars[i] = ($urandom_range(99) < 95) ? COUNT_W'($urandom_range(3))
                                                    : COUNT_W'($urandom_range(255));
         pick = $urandom_range(99);
         if (pick < 55)
            counts.ambulances[i] = '0;
         else if (pick < 85)
            counts.ambulances[i] = COUNT_W'($urandom_range(3, 1));
         else
            counts.ambulances[i] = COUNT_W'($urandom_range(255));
      end
      return counts;
   endfunction

   // Offer one item and hold it until the transfer; idle first now and then.
   task automatic send_item(input bit update, input req_type counts);
      int gap;
      gap = 0;
      if (!quiet_run && $urandom_range(99) < 5)
         gap = $urandom_range(4, 1);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= update;
      req_tdata  <= counts;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Drop valid and wait until every queued lamp state has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_reg_type index, input logic [REG_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(index));
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.write_reg(index, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_register(input csr_reg_type index);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(index));
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[REG_W-1:0] !== board.reg_value(index)) begin
         board.errors++;
         $display("%0t: register %s readback mismatch, expected %0d, actual %0d",
                  $time, index.name(), board.reg_value(index), csr_prdata[REG_W-1:0]);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Reprogram the timing while the block is idle, then read every register back.
   task automatic program_timing(input logic [REG_W-1:0] on_ticks, off_ticks,
                                 input logic [REG_W-1:0] car_ticks, empty_ticks);
      drain_results();
      write_register(REG_BLINK_ON, on_ticks);
      write_register(REG_BLINK_OFF, off_ticks);
      write_register(REG_TICKS_CAR, car_ticks);
      write_register(REG_EMPTY_GREEN, empty_ticks);
      check_register(REG_BLINK_ON);
      check_register(REG_BLINK_OFF);
      check_register(REG_TICKS_CAR);
      check_register(REG_EMPTY_GREEN);
   endtask

   task automatic program_random_timing();
      program_timing(REG_W'($urandom_range(6, 1)), REG_W'($urandom_range(6, 1)),
                     REG_W'($urandom_range(4, 1)), REG_W'($urandom_range(8, 1)));
   endtask

   // Mostly ticks with an update now and then. Optionally trigger the long result
   // hold-off, and pause the sender until everything is back, at the given items.
   task automatic random_items(input int count, input int hold_at, input int pause_at);
      for (int k = 0; k < count; k++) begin
         if (k == hold_at)
            rsp_hold_req = 1'b1;
         if (k == pause_at)
            drain_results();
         if ($urandom_range(99) < 15)
            send_item(ACT_UPDATE, random_counts());
         else
            send_item(ACT_TICK, noise_counts());
      end
   endtask

   initial begin
      board = new();
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tuser   <= ACT_TICK;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset values of the timing registers.
      check_register(REG_BLINK_ON);
      check_register(REG_BLINK_OFF);
      check_register(REG_TICKS_CAR);
      check_register(REG_EMPTY_GREEN);

      // Leave the entering phase on an update: the new counts apply before entry,
      // so approach 0 starts blinking. Then walk the count fields through their extremes
      // while the blink timer keeps running untouched.
      send_item(ACT_UPDATE, make_counts(32'h0300_0102, 32'h0000_0001));
      send_item(ACT_TICK, noise_counts());
      send_item(ACT_UPDATE, make_counts('1, '1));
      send_item(ACT_TICK, noise_counts());
      send_item(ACT_UPDATE, make_counts('0, '0));
      send_item(ACT_TICK, make_counts('1, '1));
      send_item(ACT_UPDATE, make_counts(32'hAAAA_AAAA, 32'h5555_5555));
      send_item(ACT_UPDATE, make_counts(32'h5555_5555, 32'hAAAA_AAAA));
      send_item(ACT_TICK, make_counts('0, '0));
      send_item(ACT_UPDATE, make_counts(32'h0300_0102, 32'h0000_0001));

      // Shortest timing: one tick per blink, empty green or car, after the running timer.
      program_timing(REG_W'(1), REG_W'(1), REG_W'(1), REG_W'(1));
      send_item(ACT_UPDATE, make_counts(32'h0001_0203, 32'h0100_0000));
      send_item(ACT_TICK, noise_counts());
      send_item(ACT_UPDATE, make_counts(32'h0001_0000, 32'h0000_0000));
      send_item(ACT_TICK, noise_counts());
      random_items(340, -1, -1);

      // Short random timing, with the long receiver hold-off and one full drain.
      program_random_timing();
      random_items(350, 60, 200);

      // No idling at all on either side for this stretch.
      quiet_run = 1'b1;
      program_random_timing();
      random_items(200, -1, -1);
      quiet_run = 1'b0;

      // Zero durations collapse to one tick, including a zero per-car product.
      program_timing('0, '0, '0, '0);
      random_items(200, -1, -1);

      // Longest durations last: the first expiry loads the largest timers.
      program_timing('1, '1, '1, '1);
      random_items(50, -1, -1);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Drove %0d items (%0d count updates), checked %0d lamp states.",
               items_sent, board.updates_seen, board.results_seen);
      $display("Saw %0d blinking results and %0d approach entries; timing from 0 to 65535.",
               board.blink_results, board.entries_seen);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d lamp states never arrived",
                  board.errors, board.pending());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/tlps_pkg.sv
design/tlps_csr.sv
design/tlps_seq.sv
design/tlps_out.sv
design/traffic_light_priority_sequencer_core.sv
tb/tb_traffic_light_priority_sequencer_core.sv
